### rtl/sscv_pkg.sv
// shared types and constants for the stereo sad cost volume block
// no dependencies; used by every module of the block
package sscv_pkg;

  localparam int DIM_W      = 11;
  localparam int SLOT_W     = 4;
  localparam int PIX_W      = 24;
  localparam int SUM_W      = 18;
  localparam int COST_W     = 18;
  localparam int PROD_W     = 41;
  localparam int MAX_HEIGHT = 1024;
  localparam int DEF_DISP   = 16;
  localparam int DEF_WIDTH  = 640;
  localparam int DEF_HEIGHT = 480;
  localparam int RECIP3     = 1398102;
  localparam int RECIP_SH   = 22;

  typedef enum logic [1:0] {
    REG_DISP   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [DIM_W-1:0]  col;
    logic [PIX_W-1:0]  left;
    logic [PIX_W-1:0]  right;
  } wr_cmd_t;

endpackage

### rtl/sscv_front.sv
// input side: accepts pixel and flush beats, tracks frame positions,
// writes line stores and issues output-pixel jobs; uses sscv_pkg
module sscv_front #(
  parameter int WINDOW_SIZE = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  input  logic                       kind,
  input  logic [47:0]                data,
  output logic                       s_ready,
  input  logic                       restart,
  input  logic [sscv_pkg::DIM_W-1:0] w_eff,
  input  logic [sscv_pkg::DIM_W-1:0] h_eff,
  input  logic                       q_full,
  input  logic                       q_empty,
  input  logic                       back_idle,
  output logic                       push,
  output sscv_pkg::job_t             job,
  output sscv_pkg::wr_cmd_t          wr
);

  localparam int HALF = WINDOW_SIZE / 2;
  localparam int RING = WINDOW_SIZE + 1;
  localparam int DW = sscv_pkg::DIM_W;
  localparam int SW = sscv_pkg::SLOT_W;

  logic [DW-1:0] in_row, in_col, out_row, out_col;
  logic [SW-1:0] in_slot, out_slot;
  logic          draining;

  logic [DW-1:0] in_row_next, in_col_next, out_row_next, out_col_next;
  logic [SW-1:0] in_slot_next, out_slot_next;
  logic          draining_next;

  logic          fire, pixel, frame_start, emit_pix, emit_fl;
  logic [DW-1:0] orow_b, ocol_b, orow_adv, ocol_adv;
  logic [SW-1:0] oslot_b, oslot_adv;
  logic          drain_b;

  // a pixel beat writes the line stores, so it waits until no job is reading them
  assign s_ready = kind ? !q_full : (q_empty && back_idle);
  assign fire    = s_valid && s_ready;
  assign pixel   = fire && !kind;
  assign frame_start = (in_row == '0) && (in_col == '0);

  always_comb begin
    orow_b  = (pixel && frame_start) ? '0 : out_row;
    ocol_b  = (pixel && frame_start) ? '0 : out_col;
    oslot_b = (pixel && frame_start) ? '0 : out_slot;
    drain_b = (pixel && frame_start) ? 1'b0 : draining;

    emit_pix = pixel && (in_row >= DW'(HALF + 1)) && (orow_b < h_eff);
    emit_fl  = fire && kind && draining && (out_row < h_eff);

    ocol_adv  = ocol_b + 1'b1;
    orow_adv  = orow_b;
    oslot_adv = oslot_b;
    if (ocol_adv >= w_eff) begin
      ocol_adv  = '0;
      orow_adv  = orow_b + 1'b1;
      oslot_adv = (oslot_b == SW'(RING - 1)) ? '0 : oslot_b + 1'b1;
    end

    out_row_next  = orow_b;
    out_col_next  = ocol_b;
    out_slot_next = oslot_b;
    if (emit_pix || emit_fl) begin
      out_row_next  = orow_adv;
      out_col_next  = ocol_adv;
      out_slot_next = oslot_adv;
    end

    in_row_next   = in_row;
    in_col_next   = in_col;
    in_slot_next  = in_slot;
    draining_next = drain_b;
    if (pixel) begin
      in_col_next = in_col + 1'b1;
      if (in_col_next >= w_eff) begin
        in_col_next  = '0;
        in_row_next  = in_row + 1'b1;
        in_slot_next = (in_slot == SW'(RING - 1)) ? '0 : in_slot + 1'b1;
        if (in_row_next >= h_eff) begin
          in_row_next   = '0;
          in_slot_next  = '0;
          draining_next = (out_row_next < h_eff);
        end
      end
    end else if (emit_fl && (out_row_next >= h_eff)) begin
      draining_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
      draining <= 1'b0;
    end else begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_slot  <= in_slot_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_slot <= out_slot_next;
      draining <= draining_next;
    end
  end

  assign push     = emit_pix || emit_fl;
  assign job.row  = orow_b;
  assign job.col  = ocol_b;
  assign job.slot = oslot_b;

  assign wr.en    = pixel;
  assign wr.slot  = in_slot;
  assign wr.col   = in_col;
  assign wr.left  = data[23:0];
  assign wr.right = data[47:24];

endmodule

### rtl/sscv_fifo.sv
// two-entry job queue between the input side and the cost engine
// uses sscv_pkg for the job type
module sscv_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sscv_pkg::job_t din,
  input  logic           pop,
  output sscv_pkg::job_t dout,
  output logic           empty,
  output logic           full
);

  sscv_pkg::job_t slots [2];
  logic           wptr, rptr;
  logic [1:0]     count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### rtl/sscv_back.sv
// cost engine: holds both line stores, walks the window per disparity with
// one shared accumulator pair, scales by 4/3 and drives the result beat; uses sscv_pkg
module sscv_back #(
  parameter int WINDOW_SIZE   = 5,
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_WIDTH     = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   job_valid,
  input  sscv_pkg::job_t                         job_in,
  output logic                                   job_pop,
  input  sscv_pkg::wr_cmd_t                      wr,
  input  logic [sscv_pkg::DIM_W-1:0]             w_eff,
  input  logic [sscv_pkg::DIM_W-1:0]             h_eff,
  input  logic [$clog2(MAX_DISPARITY+1)-1:0]     n_eff,
  output logic                                   idle,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [63:0]                            m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int HALF  = WINDOW_SIZE / 2;
  localparam int RING  = WINDOW_SIZE + 1;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int DEPTH = RING * (2 ** COL_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DISPARITY + 1);
  localparam int WC_W  = $clog2(WINDOW_SIZE);
  localparam int NW    = sscv_pkg::DIM_W;
  localparam int SGW   = NW + 2;
  localparam int SW    = sscv_pkg::SLOT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_READ  = 6'b000100,
    S_LAST  = 6'b001000,
    S_MUL   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t             state;
  sscv_pkg::job_t     jb;
  logic [DW-1:0]      d;
  logic [WC_W-1:0]    dri, dci;
  logic [NW-1:0]      ls, rs;
  logic               rd_valid;
  logic [sscv_pkg::SUM_W-1:0]  lacc, racc;
  logic [sscv_pkg::PROD_W-1:0] lprod, rprod;

  logic [sscv_pkg::PIX_W-1:0] lmem [DEPTH];
  logic [sscv_pkg::PIX_W-1:0] rmem [DEPTH];
  logic [sscv_pkg::PIX_W-1:0] lq0, lq1, rq0, rq1;

  logic [NW-1:0]   d_ext, ls_c, rs_c;
  logic [NW:0]     c_plus;
  logic [SW-1:0]   slot_c;
  logic [AW-1:0]   la0, la1, ra0, ra1, wa;
  logic            load_out, last_d;

  function automatic logic [COL_W-1:0] clampcol(input logic [NW-1:0] base,
                                                input logic [WC_W-1:0] dc,
                                                input logic [NW-1:0] w);
    logic signed [SGW-1:0] x;
    logic signed [SGW-1:0] wm1;
    x   = $signed({2'b00, base}) + $signed({{(SGW-WC_W){1'b0}}, dc}) - signed'(SGW'(HALF));
    wm1 = $signed({2'b00, w}) - signed'(SGW'(1));
    if (x < 0) x = '0;
    else if (x > wm1) x = wm1;
    return x[COL_W-1:0];
  endfunction

  function automatic logic [9:0] sad3(input logic [23:0] a, input logic [23:0] b);
    logic [7:0] e0, e1, e2;
    e0 = (a[7:0]   > b[7:0])   ? a[7:0]   - b[7:0]   : b[7:0]   - a[7:0];
    e1 = (a[15:8]  > b[15:8])  ? a[15:8]  - b[15:8]  : b[15:8]  - a[15:8];
    e2 = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    return {2'b00, e0} + {2'b00, e1} + {2'b00, e2};
  endfunction

  // shifted centres for this disparity, falling back to the pixel itself
  always_comb begin
    d_ext  = NW'(d);
    ls_c   = (jb.col >= d_ext) ? jb.col - d_ext : jb.col;
    c_plus = {1'b0, jb.col} + {1'b0, d_ext};
    rs_c   = (c_plus <= ({1'b0, w_eff} - 1'b1)) ? c_plus[NW-1:0] : jb.col;
  end

  // ring slot of the clamped window row
  always_comb begin
    logic signed [SGW-1:0] r_s, rr, k, sl, h1;
    r_s = $signed({2'b00, jb.row});
    h1  = $signed({2'b00, h_eff}) - signed'(SGW'(1));
    rr  = r_s + $signed({{(SGW-WC_W){1'b0}}, dri}) - signed'(SGW'(HALF));
    if (rr < 0) rr = '0;
    else if (rr > h1) rr = h1;
    k  = rr - r_s;
    sl = $signed({{(SGW-SW){1'b0}}, jb.slot}) + k;
    if (sl < 0) sl = sl + signed'(SGW'(RING));
    else if (sl >= signed'(SGW'(RING))) sl = sl - signed'(SGW'(RING));
    slot_c = sl[SW-1:0];
  end

  assign la0 = AW'({slot_c, clampcol(jb.col, dci, w_eff)});
  assign la1 = AW'({slot_c, clampcol(rs, dci, w_eff)});
  assign ra0 = AW'({slot_c, clampcol(ls, dci, w_eff)});
  assign ra1 = la0;
  assign wa  = AW'({wr.slot, wr.col[COL_W-1:0]});

  always_ff @(posedge clk) begin
    if (wr.en) lmem[wa] <= wr.left;
    lq0 <= lmem[la0];
    lq1 <= lmem[la1];
  end

  always_ff @(posedge clk) begin
    if (wr.en) rmem[wa] <= wr.right;
    rq0 <= rmem[ra0];
    rq1 <= rmem[ra1];
  end

  assign idle     = (state == S_IDLE);
  assign job_pop  = idle && job_valid;
  assign last_d   = (d == n_eff - 1'b1);
  assign load_out = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ);
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) state <= S_SETUP;
        end
        S_SETUP: state <= S_READ;
        S_READ: begin
          if (dci == WC_W'(WINDOW_SIZE - 1) && dri == WC_W'(WINDOW_SIZE - 1)) state <= S_LAST;
        end
        S_LAST: state <= S_MUL;
        S_MUL:  state <= S_EMIT;
        S_EMIT: begin
          if (load_out) state <= last_d ? S_IDLE : S_SETUP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      jb <= job_in;
      d  <= '0;
    end
    if (state == S_SETUP) begin
      ls   <= ls_c;
      rs   <= rs_c;
      dri  <= '0;
      dci  <= '0;
      lacc <= '0;
      racc <= '0;
    end else begin
      if (rd_valid) begin
        lacc <= lacc + sscv_pkg::SUM_W'(sad3(lq0, rq0));
        racc <= racc + sscv_pkg::SUM_W'(sad3(lq1, rq1));
      end
      if (state == S_READ) begin
        if (dci == WC_W'(WINDOW_SIZE - 1)) begin
          dci <= '0;
          dri <= dri + 1'b1;
        end else begin
          dci <= dci + 1'b1;
        end
      end
    end
    // floor(4*sum/3) by reciprocal multiply
    if (state == S_MUL) begin
      lprod <= sscv_pkg::PROD_W'({lacc, 2'b00}) * sscv_pkg::PROD_W'(sscv_pkg::RECIP3);
      rprod <= sscv_pkg::PROD_W'({racc, 2'b00}) * sscv_pkg::PROD_W'(sscv_pkg::RECIP3);
    end
    if (load_out) begin
      m_axis_tdata <= {2'b00,
                       rprod[sscv_pkg::RECIP_SH +: sscv_pkg::COST_W],
                       lprod[sscv_pkg::RECIP_SH +: sscv_pkg::COST_W],
                       6'(d), 10'(jb.col), 10'(jb.row)};
      m_axis_tlast <= last_d;
      if (!last_d) d <= d + 1'b1;
    end
  end

endmodule

### rtl/stereo_sad_cost_volume.sv
// stereo sad cost volume, top level: register port, input side, job queue, cost engine
// depends on sscv_pkg, sscv_front, sscv_fifo, sscv_back
// each job walks the states setup, window read, last, multiply and emit once per disparity,
// one disparity after another in the shared window accumulator pair,
// so a pixel beat is taken only once the job queue is empty and the cost engine is idle
// reset: registers to 16/640/480, positions zero; line stores are not cleared
module stereo_sad_cost_volume #(
  parameter int WINDOW_SIZE   = 5,
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_WIDTH     = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // left_red, left_green, left_blue, right_red, right_green, right_blue
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // pixel_row, pixel_col, disparity, left_cost, right_cost, pad
  output logic        m_axis_tlast,  // last_of_pixel
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = $clog2(MAX_DISPARITY + 1);
  localparam int NW = sscv_pkg::DIM_W;

  logic [6:0]    disp_cnt;
  logic [NW-1:0] img_w, img_h, w_eff, h_eff;
  logic [DW-1:0] n_eff;
  logic          wr_go, restart;

  sscv_pkg::job_t    job_f, job_q;
  sscv_pkg::wr_cmd_t wr;
  logic push, pop, q_empty, q_full, back_idle;

  assign pready = 1'b1;
  assign wr_go  = psel && penable && pwrite;
  assign restart = wr_go && (paddr[3:2] == sscv_pkg::REG_WIDTH ||
                             paddr[3:2] == sscv_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_cnt <= 7'(sscv_pkg::DEF_DISP);
      img_w    <= NW'(sscv_pkg::DEF_WIDTH);
      img_h    <= NW'(sscv_pkg::DEF_HEIGHT);
    end else if (wr_go) begin
      case (paddr[3:2])
        sscv_pkg::REG_DISP:   disp_cnt <= pwdata[6:0];
        sscv_pkg::REG_WIDTH:  img_w    <= pwdata[NW-1:0];
        sscv_pkg::REG_HEIGHT: img_h    <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sscv_pkg::REG_DISP:   prdata = {25'd0, disp_cnt};
      sscv_pkg::REG_WIDTH:  prdata = {{(32-NW){1'b0}}, img_w};
      sscv_pkg::REG_HEIGHT: prdata = {{(32-NW){1'b0}}, img_h};
      default:              prdata = '0;
    endcase
  end

  // out-of-range register values act as the nearest legal value
  always_comb begin
    if (img_w == '0) w_eff = NW'(1);
    else if (img_w > NW'(MAX_WIDTH)) w_eff = NW'(MAX_WIDTH);
    else w_eff = img_w;
    if (img_h == '0) h_eff = NW'(1);
    else if (img_h > NW'(sscv_pkg::MAX_HEIGHT)) h_eff = NW'(sscv_pkg::MAX_HEIGHT);
    else h_eff = img_h;
    if (disp_cnt == '0) n_eff = DW'(1);
    else if (disp_cnt > 7'(MAX_DISPARITY)) n_eff = DW'(MAX_DISPARITY);
    else n_eff = DW'(disp_cnt);
  end

  sscv_front #(.WINDOW_SIZE(WINDOW_SIZE)) u_front (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .kind(s_axis_tuser), .data(s_axis_tdata),
    .s_ready(s_axis_tready), .restart(restart),
    .w_eff(w_eff), .h_eff(h_eff),
    .q_full(q_full), .q_empty(q_empty), .back_idle(back_idle),
    .push(push), .job(job_f), .wr(wr)
  );

  sscv_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .din(job_f), .pop(pop), .dout(job_q),
    .empty(q_empty), .full(q_full)
  );

  sscv_back #(
    .WINDOW_SIZE(WINDOW_SIZE), .MAX_DISPARITY(MAX_DISPARITY), .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst),
    .job_valid(!q_empty), .job_in(job_q), .job_pop(pop), .wr(wr),
    .w_eff(w_eff), .h_eff(h_eff), .n_eff(n_eff), .idle(back_idle),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

endmodule
